### sv/btlv_pkg.sv
package btlv_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_TAG      = 3'd0,
    PH_LEN      = 3'd1,
    PH_LENBYTES = 3'd2,
    PH_CONTENT  = 3'd3,
    PH_DISCARD  = 3'd4
  } phase_t;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INDEFINITE = 3'd1;
  localparam logic [2:0] ST_TOO_MANY   = 3'd2;
  localparam logic [2:0] ST_WRONG_LEN  = 3'd3;
  localparam logic [2:0] ST_EARLY_END  = 3'd4;

  // Long-form length marker bit and largest content length
  localparam int unsigned LONG_FORM_BIT   = 7;
  localparam logic [31:0] MAX_CONTENT_LEN = 32'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         tag;
    logic signed [31:0] value;
    logic [2:0]         status;
  } out_item_t;

endpackage

### sv/btlv_in_stage.sv
module btlv_in_stage
  import btlv_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     item_valid,
  output in_item_t item,
  input  logic     take
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;

  // Holds one request; a new one loads when the slot is empty or drains.
  assign in_stall  = valid_r && !take;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = data_r;

endmodule

### sv/btlv_parser.sv
module btlv_parser
  import btlv_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      item_valid,
  input  in_item_t  item,
  input  logic      out_free,
  output logic      take,
  output logic      res_valid,
  output out_item_t res
);

  localparam logic [6:0] MaxCnt = 7'(MAX_LENGTH_BYTES);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [3:0]  bytes_left_r, bytes_left_nxt;
  logic [31:0] len_r, len_nxt;
  logic        big_r, big_nxt;
  logic [2:0]  content_left_r, content_left_nxt;
  logic [31:0] acc_r, acc_nxt;

  logic        produce;
  logic        fire;
  logic [2:0]  status;
  logic [31:0] value;

  // One request per cycle; only a request that yields a result waits on the output.
  assign fire = item_valid && (out_free || !produce);
  assign take = fire;

  always_comb begin
    logic [7:0]  b;
    logic        last;
    logic [6:0]  cnt;
    logic        done;
    logic        err_set;
    logic [2:0]  err;
    logic [31:0] acc_base;

    b                = item.data_byte;
    last             = item.buffer_end;
    cnt              = b[6:0];
    done             = 1'b0;
    err_set          = 1'b0;
    err              = ST_OK;
    acc_base         = acc_r;
    phase_nxt        = phase_r;
    tag_nxt          = tag_r;
    bytes_left_nxt   = bytes_left_r;
    len_nxt          = len_r;
    big_nxt          = big_r;
    content_left_nxt = content_left_r;
    acc_nxt          = acc_r;
    produce          = 1'b0;
    status           = ST_OK;
    value            = '0;

    unique case (phase_r)
      PH_TAG: begin
        tag_nxt = b;
        if (last) begin
          err_set = 1'b1;
          err     = ST_EARLY_END;
        end else begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b[LONG_FORM_BIT]) begin
          if (cnt == 7'd0) begin
            err_set = 1'b1;
            err     = ST_INDEFINITE;
          end else if (cnt > MaxCnt) begin
            err_set = 1'b1;
            err     = ST_TOO_MANY;
          end else if (last) begin
            err_set = 1'b1;
            err     = ST_EARLY_END;
          end else begin
            bytes_left_nxt = cnt[3:0];
            len_nxt        = '0;
            big_nxt        = 1'b0;
            phase_nxt      = PH_LENBYTES;
          end
        end else begin
          len_nxt = {24'd0, b};
          big_nxt = 1'b0;
          done    = 1'b1;
        end
      end
      PH_LENBYTES: begin
        if (len_r[31:24] != 8'd0) begin
          big_nxt = 1'b1;
        end
        len_nxt        = {len_r[23:0], b};
        bytes_left_nxt = bytes_left_r - 4'd1;
        if (bytes_left_nxt == 4'd0) begin
          done = 1'b1;
        end else if (last) begin
          err_set = 1'b1;
          err     = ST_EARLY_END;
        end
      end
      PH_CONTENT: begin
        // first content byte sets the sign
        if ((content_left_r == len_r[2:0]) && b[7]) begin
          acc_base = '1;
        end
        acc_nxt          = {acc_base[23:0], b};
        content_left_nxt = content_left_r - 3'd1;
        if (content_left_nxt == 3'd0) begin
          produce   = 1'b1;
          status    = ST_OK;
          value     = acc_nxt;
          phase_nxt = PH_TAG;
        end else if (last) begin
          err_set = 1'b1;
          err     = ST_EARLY_END;
        end
      end
      PH_DISCARD: begin
      end
      default: begin
      end
    endcase

    // length complete: wrong length is checked before early end
    if (done) begin
      if (big_nxt || (len_nxt == 32'd0) || (len_nxt > MAX_CONTENT_LEN)) begin
        err_set = 1'b1;
        err     = ST_WRONG_LEN;
      end else if (last) begin
        err_set = 1'b1;
        err     = ST_EARLY_END;
      end else begin
        content_left_nxt = len_nxt[2:0];
        acc_nxt          = '0;
        phase_nxt        = PH_CONTENT;
      end
    end

    if (err_set) begin
      produce   = 1'b1;
      status    = err;
      value     = '0;
      phase_nxt = PH_DISCARD;
    end
    if (last) begin
      phase_nxt = PH_TAG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_TAG;
      tag_r          <= '0;
      bytes_left_r   <= '0;
      len_r          <= '0;
      big_r          <= 1'b0;
      content_left_r <= '0;
      acc_r          <= '0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      tag_r          <= tag_nxt;
      bytes_left_r   <= bytes_left_nxt;
      len_r          <= len_nxt;
      big_r          <= big_nxt;
      content_left_r <= content_left_nxt;
      acc_r          <= acc_nxt;
    end
  end

  assign res_valid  = fire && produce;
  assign res.tag    = tag_nxt;
  assign res.value  = value;
  assign res.status = status;

`ifndef SYNTHESIS
  a_last_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.buffer_end |=> phase_r == PH_TAG)
    else $error("buffer end did not return parser to tag phase");

  a_ok_to_tag: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status == ST_OK) |=> phase_r == PH_TAG)
    else $error("completed element did not return parser to tag phase");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && (res.status != ST_OK) |-> res.value == 32'sd0)
    else $error("error result carries nonzero value");

  a_content_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_CONTENT |->
      !big_r && (len_r != 32'd0) && (len_r <= MAX_CONTENT_LEN) &&
      (content_left_r != 3'd0))
    else $error("content phase entered with bad length");
`endif

endmodule

### sv/btlv_out_stage.sv
module btlv_out_stage
  import btlv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_item_t res,
  output logic      out_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign out_free  = !valid_r || !out_stall;
  assign valid_nxt = out_free ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

### sv/ber_integer_tlv_decoder.sv
// BER integer TLV decoder.
// Input channel (in_valid / in_stall / in_data): one byte of the encoded
// buffer per request, with buffer_end set on the last byte of a buffer.
// Output channel (out_valid / out_stall / out_data): one request per parsed
// element (tag, sign-extended 1..4 byte value, status 0) or per error
// (status 1..4, value 0). After an error the rest of the buffer is dropped.
// Pipeline: input register -> parse logic -> result register; each byte's
// result is registered in the result register before out_data shows it.
// Throughput is one byte per cycle unless a result waits on a stalled
// receiver; the single parse stage holds the only per-byte state loop.
// Bytes that give no result never wait on the output side. When the
// receiver stalls with a result held, a byte that would give a result waits
// in the input register and in_stall rises; the held result stays stable.
// Reset (rst_n low, synchronous) empties both registers and returns the
// parser to expecting a tag byte.
module ber_integer_tlv_decoder
  import btlv_pkg::*;
#(
  parameter int unsigned MAX_LENGTH_BYTES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic      item_valid;
  in_item_t  item;
  logic      take;
  logic      res_valid;
  out_item_t res;
  logic      out_free;

  // input register
  btlv_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  // element state and per-byte decode
  btlv_parser #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  btlv_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
